/* rtl/tdpt_pkg.sv */
// Shared types and constants for the trial-division prime test unit.
// No dependencies.
`default_nettype none

package tdpt_pkg;

  localparam int unsigned ECHO_W = 32;
  localparam int unsigned FIRST_DIVISOR = 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } tdpt_state_e;

endpackage

`default_nettype wire

/* rtl/trial_division_prime_test_unit.sv */
// Top level: trial-division primality test sequencer around one shared divider.
// Uses tdpt_pkg and tdpt_divider.
`default_nettype none

// A word is taken when start_i is high while busy_o is low; busy_o stays high
// until the answer is out. The answer (candidate_echo_o, prime_flag_o) shows
// for exactly one cycle with done_o and must be captured then. Candidates 0
// and 1 answer in the cycle after start. Otherwise each trial divisor d, from 2
// upward, goes through the serial divider, which also yields n / d for the
// d <= n / d bound; a prime n is declared once d exceeds n / d, and a
// composite stops at its smallest factor p.
module trial_division_prime_test_unit
  import tdpt_pkg::*;
#(
  parameter int unsigned NUM_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ECHO_W-1:0] candidate_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [ECHO_W-1:0]      candidate_echo_o,
  output logic                   prime_flag_o
);

  tdpt_state_e          state_q, state_d;
  logic [NUM_WIDTH-1:0] cand_n;
  logic [NUM_WIDTH-1:0] n_q, n_d;
  logic [NUM_WIDTH-1:0] d_q, d_d;
  logic                 go_q, go_d;
  logic                 done_q, done_d;
  logic                 prime_q, prime_d;
  logic [ECHO_W-1:0]    echo_q, echo_d;
  logic [ECHO_W-1:0]    n_echo;
  logic [ECHO_W-1:0]    cand_echo;
  logic                 div_done;
  logic [NUM_WIDTH-1:0] div_quo;
  logic [NUM_WIDTH-1:0] div_rem;
  logic                 accept;

  if (NUM_WIDTH <= ECHO_W) begin : g_narrow
    assign cand_n = candidate_i[NUM_WIDTH-1:0];
  end else begin : g_wide
    assign cand_n = {{(NUM_WIDTH - ECHO_W){1'b0}}, candidate_i};
  end

  if (NUM_WIDTH >= ECHO_W) begin : g_echo_trunc
    assign cand_echo = cand_n[ECHO_W-1:0];
    assign n_echo    = n_q[ECHO_W-1:0];
  end else begin : g_echo_ext
    assign cand_echo = {{(ECHO_W - NUM_WIDTH){1'b0}}, cand_n};
    assign n_echo    = {{(ECHO_W - NUM_WIDTH){1'b0}}, n_q};
  end

  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    d_d     = d_q;
    go_d    = 1'b0;
    done_d  = 1'b0;
    prime_d = prime_q;
    echo_d  = echo_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_d = cand_n;
          if (cand_n[NUM_WIDTH-1:1] == '0) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
            echo_d  = cand_echo;
          end else begin
            d_d     = NUM_WIDTH'(FIRST_DIVISOR);
            go_d    = 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (d_q > div_quo) begin
            done_d  = 1'b1;
            prime_d = 1'b1;
            echo_d  = n_echo;
            state_d = ST_IDLE;
          end else if (div_rem == '0) begin
            done_d  = 1'b1;
            prime_d = 1'b0;
            echo_d  = n_echo;
            state_d = ST_IDLE;
          end else begin
            d_d  = d_q + NUM_WIDTH'(1);
            go_d = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      go_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    prime_q <= prime_d;
    echo_q  <= echo_d;
  end

  tdpt_divider #(
    .W (NUM_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (go_q),
    .dividend_i  (n_q),
    .divisor_i   (d_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign candidate_echo_o = echo_q;
  assign prime_flag_o     = prime_q;

endmodule

`default_nettype wire

/* rtl/tdpt_divider.sv */
// Restoring radix-2 divider, one quotient bit per cycle; quotient and remainder.
// Uses tdpt_pkg.
`default_nettype none

module tdpt_divider
  import tdpt_pkg::*;
#(
  parameter int unsigned W = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quotient_o,
  output logic [W-1:0]      remainder_o
);

  localparam int unsigned CNT_W = $clog2(W);

  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;
  logic [W-1:0]     dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [W:0]       shifted;
  logic [W:0]       diff;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      dvs_d = divisor_i;
      cnt_d = CNT_W'(W - 1);
      run_d = 1'b1;
    end else if (run_q) begin
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* bench/trial_division_prime_test_unit_tb.sv */
// Self-checking bench for trial_division_prime_test_unit: drives candidate words,
// predicts each primality answer by trial division and checks every done_o strobe.
// Depends on tdpt_pkg and the RTL of the unit.
`timescale 1ns / 100ps

module trial_division_prime_test_unit_tb;
  import tdpt_pkg::*;

  localparam int unsigned NUM_W      = 32;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYC  = 40;
  localparam int unsigned RAND_WORDS = 100;

  typedef struct packed {
    logic [ECHO_W-1:0] echo;
    logic              prime;
  } prime_answer_t;

  function automatic logic prime_by_trial(logic [63:0] n);
    logic [63:0] d;
    if (n < 64'd2) return 1'b0;
    for (d = 64'd2; d <= n / d; d++) begin
      if (n % d == 64'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_answer_t predict_answer(logic [ECHO_W-1:0] cand);
    logic [63:0]   num_mask;
    logic [63:0]   n;
    prime_answer_t a;
    num_mask = ((64'd1 << (NUM_W - 1)) << 1) - 64'd1;
    n        = {32'd0, cand} & num_mask;
    a.echo   = n[ECHO_W-1:0];
    a.prime  = prime_by_trial(n);
    return a;
  endfunction

  class prime_scoreboard;
    prime_answer_t answers_q[$];
    int unsigned   fails;
    int unsigned   checked;
    int unsigned   primes_seen;

    function new();
      fails       = 0;
      checked     = 0;
      primes_seen = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      fails++;
    endtask

    function void note_word(logic [ECHO_W-1:0] cand);
      answers_q.push_back(predict_answer(cand));
    endfunction

    task check_answer(logic [ECHO_W-1:0] echo, logic prime);
      prime_answer_t exp_a;
      if (answers_q.size() == 0) begin
        report($sformatf("unexpected answer echo=%0d prime=%0b", echo, prime));
      end else begin
        exp_a = answers_q.pop_front();
        checked++;
        if (exp_a.prime) primes_seen++;
        if (echo !== exp_a.echo)
          report($sformatf("candidate_echo %0d, want %0d", echo, exp_a.echo));
        if (prime !== exp_a.prime)
          report($sformatf("prime_flag %0b for %0d, want %0b",
                           prime, exp_a.echo, exp_a.prime));
      end
    endtask

    function int unsigned pending();
      return answers_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic [ECHO_W-1:0] candidate_i;
  logic              busy_o;
  logic              done_o;
  logic [ECHO_W-1:0] candidate_echo_o;
  logic              prime_flag_o;

  prime_scoreboard sb = new();
  int unsigned     idle_cycles;
  int unsigned     words_sent;

  trial_division_prime_test_unit #(
    .NUM_WIDTH(NUM_W)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .candidate_i     (candidate_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .candidate_echo_o(candidate_echo_o),
    .prime_flag_o    (prime_flag_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_answer(candidate_echo_o, prime_flag_o);
  end

  // watchdog: cycles with no word taken and no answer
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress in %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic [ECHO_W-1:0] cand, int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i     <= 1'b1;
    candidate_i <= cand;
    do @(posedge clk_i); while (busy_o);
    sb.note_word(cand);
    words_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [ECHO_W-1:0] random_candidate();
    int unsigned       sel;
    int unsigned       p;
    logic [ECHO_W-1:0] k;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return $urandom_range(0, 65535);
    if (sel <= 7) return $urandom_range(0, 1 << 20);
    // large word with a small factor keeps the search short
    case ($urandom_range(0, 5))
      0: p = 2;
      1: p = 3;
      2: p = 5;
      3: p = 7;
      4: p = 11;
      default: p = 13;
    endcase
    k = $urandom_range(1, 32'hFFFF_FFFF / p);
    return k * p;
  endfunction

  logic [ECHO_W-1:0] directed_words[] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd97,
    32'd121, 32'd63001, 32'd65521, 32'd65536, 32'd1000003, 32'd1018081,
    32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
    32'hAAAA_AAAA, 32'h5555_5555
  };

  initial begin
    bit no_gaps;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    candidate_i = '0;
    words_sent  = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_words[i]) send_word(directed_words[i], $urandom_range(0, 6));

    no_gaps = 1'b0;
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 10 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_word(random_candidate(), no_gaps ? 0 : $urandom_range(0, 6));
    end
    start_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (sb.pending() != 0) sb.report($sformatf("%0d answers never came", sb.pending()));
    $display("sent %0d candidate words (%0d directed), checked %0d answers, %0d prime",
             words_sent, directed_words.size(), sb.checked, sb.primes_seen);
    $display("mismatches: %0d", sb.fails);
    if (sb.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tdpt_pkg.sv
rtl/tdpt_divider.sv
rtl/trial_division_prime_test_unit.sv
bench/trial_division_prime_test_unit_tb.sv
